@@ rtl/rsc_pkg.sv @@
`default_nettype none

package rsc_pkg;

  localparam int VAL_W    = 48;
  localparam int MAG_W    = 2 * VAL_W;
  localparam int STATUS_W = 3;
  localparam int DIGIT_W  = 4;
  localparam int OP_W     = 2;

  localparam int DEF_STACK_DEPTH   = 32;
  localparam int DEF_FRACTION_BITS = 16;

  localparam logic               KIND_DIGIT = 1'b0;
  localparam logic               KIND_OPER  = 1'b1;
  localparam logic [DIGIT_W-1:0] MAX_DIGIT  = 4'd9;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_MALFORMED,
    ST_OVERFLOW,
    ST_DIVZERO,
    ST_SATURATED
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FETCH,
    S_ARITH,
    S_CLOSE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             load_tok;
    logic             push;
    logic             set_err;
    status_t          err_code;
    logic             rd_operands;
    logic             write_res;
    logic             start_mul;
    logic             start_div;
    logic             rd_bottom;
    logic             close_check;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic last;
    op_t  op;
    logic digit_bad;
    logic full;
    logic lt2;
    logic hard;
    logic right_zero;
    logic unit_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } arith_res_t;

  function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
    return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

  // Apply sign to an unsigned magnitude, clamping to the 48-bit range.
  function automatic arith_res_t sat_pack(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0] limit;
    logic [VAL_W-1:0] low;
    arith_res_t       r;
    limit = MAG_W'(VAL_MAX) + MAG_W'(neg);
    low   = mag[VAL_W-1:0];
    r.sat = mag > limit;
    if (r.sat) begin
      r.value = neg ? VAL_MIN : VAL_MAX;
    end else begin
      r.value = neg ? (~low + VAL_W'(1)) : low;
    end
    return r;
  endfunction

  function automatic logic is_hard(input status_t e);
    return (e != ST_OK) && (e != ST_SATURATED);
  endfunction

endpackage

`default_nettype wire

@@ rtl/rsc_if.sv @@
`default_nettype none

interface rsc_tok_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [rsc_pkg::DIGIT_W-1:0] digit_value;
  logic [rsc_pkg::OP_W-1:0]    op_code;
  logic                        last_token;

  modport source(output valid, kind, digit_value, op_code, last_token, input ready);
  modport sink(input valid, kind, digit_value, op_code, last_token, output ready);
endinterface

interface rsc_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsc_pkg::VAL_W-1:0]    value;
  logic        [rsc_pkg::STATUS_W-1:0] status;

  modport source(output valid, value, status, input ready);
  modport sink(input valid, value, status, output ready);
endinterface

`default_nettype wire

@@ rtl/rsc_mul.sv @@
`default_nettype none

module rsc_mul #(
  parameter int FRACTION_BITS = rsc_pkg::DEF_FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [rsc_pkg::VAL_W-1:0] a,
  input  logic signed [rsc_pkg::VAL_W-1:0] b,
  output logic                             done,
  output rsc_pkg::arith_res_t              res
);
  import rsc_pkg::*;

  localparam int HW        = VAL_W / 2;
  localparam int SHW       = $clog2(VAL_W + 1);
  localparam int MUL_STEPS = 4;

  logic [VAL_W-1:0] ma, mb;
  logic             neg;
  logic             busy;
  logic [2:0]       cnt;
  logic [2*HW-1:0]  pp;
  logic [SHW-1:0]   psh;
  logic [MAG_W-1:0] acc;
  logic [HW-1:0]    a_half, b_half;
  logic [SHW-1:0]   shift;

  // cnt[0] picks the half of a, cnt[1] the half of b
  assign a_half = cnt[0] ? ma[VAL_W-1:HW] : ma[HW-1:0];
  assign b_half = cnt[1] ? mb[VAL_W-1:HW] : mb[HW-1:0];

  always_comb begin
    case (cnt[1:0])
      2'b00:   shift = '0;
      2'b11:   shift = SHW'(2 * HW);
      default: shift = SHW'(HW);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'(MUL_STEPS + 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= magnitude(a);
      mb  <= magnitude(b);
      neg <= a[VAL_W-1] ^ b[VAL_W-1];
      acc <= '0;
    end else if (busy) begin
      if (cnt < 3'(MUL_STEPS)) begin
        pp  <= a_half * b_half;
        psh <= shift;
      end
      // accumulate the partial product registered on the previous cycle
      if (cnt >= 3'd1 && cnt <= 3'(MUL_STEPS)) begin
        acc <= acc + (MAG_W'(pp) << psh);
      end
      if (cnt == 3'(MUL_STEPS + 1)) begin
        res <= sat_pack(acc >> FRACTION_BITS, neg);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/rsc_div.sv @@
`default_nettype none

module rsc_div #(
  parameter int FRACTION_BITS = rsc_pkg::DEF_FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [rsc_pkg::VAL_W-1:0] a,
  input  logic signed [rsc_pkg::VAL_W-1:0] b,
  output logic                             done,
  output rsc_pkg::arith_res_t              res
);
  import rsc_pkg::*;

  localparam int NW  = VAL_W + FRACTION_BITS;
  localparam int NCW = $clog2(NW + 1);

  // numerator shifts out at the top while quotient bits enter at the bottom
  logic [NW-1:0]    nq;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] ub;
  logic             neg;
  logic             busy;
  logic             fin;
  logic [NCW-1:0]   cnt;
  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;
  logic             ge;

  assign trial = {rem, nq[NW-1]};
  assign diff  = trial - {1'b0, ub};
  assign ge    = trial >= {1'b0, ub};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NCW'(NW);
      end else if (busy) begin
        cnt <= cnt - NCW'(1);
        if (cnt == NCW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= NW'(magnitude(a)) << FRACTION_BITS;
      rem <= '0;
      ub  <= magnitude(b);
      neg <= a[VAL_W-1] ^ b[VAL_W-1];
    end else if (busy) begin
      rem <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      nq  <= {nq[NW-2:0], ge};
    end else if (fin) begin
      res <= sat_pack(MAG_W'(nq), neg);
    end
  end

endmodule

`default_nettype wire

@@ rtl/rsc_dp.sv @@
`default_nettype none

module rsc_dp #(
  parameter int STACK_DEPTH   = rsc_pkg::DEF_STACK_DEPTH,
  parameter int FRACTION_BITS = rsc_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tok_kind,
  input  logic [rsc_pkg::DIGIT_W-1:0]         tok_digit,
  input  logic [rsc_pkg::OP_W-1:0]            tok_op,
  input  logic                                tok_last,
  input  rsc_pkg::cmd_t                       cmd,
  output rsc_pkg::stat_t                      stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [rsc_pkg::VAL_W-1:0]    out_value,
  output logic        [rsc_pkg::STATUS_W-1:0] out_status
);
  import rsc_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic               kind;
  logic [DIGIT_W-1:0] digit;
  op_t                op;
  logic               last;
  logic [CW-1:0]      count;
  status_t            err;

  logic [VAL_W-1:0]        mem [STACK_DEPTH];
  logic signed [VAL_W-1:0] rd_a;  // right operand, or bottom entry on close
  logic signed [VAL_W-1:0] rd_b;  // left operand

  logic [CW-1:0]    count_m1, count_m2;
  logic [VAL_W-1:0] digit_fx;
  logic [VAL_W:0]   sum;
  arith_res_t       addsub_res, mul_res, div_res, res;
  logic             mul_done, div_done;

  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);
  assign digit_fx = VAL_W'(digit) << FRACTION_BITS;

  always_comb begin
    if (op == OP_SUB) begin
      sum = {rd_b[VAL_W-1], rd_b} - {rd_a[VAL_W-1], rd_a};
    end else begin
      sum = {rd_b[VAL_W-1], rd_b} + {rd_a[VAL_W-1], rd_a};
    end
    addsub_res.sat = sum[VAL_W] ^ sum[VAL_W-1];
    if (addsub_res.sat) begin
      addsub_res.value = sum[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      addsub_res.value = sum[VAL_W-1:0];
    end
  end

  always_comb begin
    case (op)
      OP_MUL:  res = mul_res;
      OP_DIV:  res = div_res;
      default: res = addsub_res;
    endcase
  end

  rsc_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_mul),
    .a     (rd_b),
    .b     (rd_a),
    .done  (mul_done),
    .res   (mul_res)
  );

  rsc_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_div),
    .a     (rd_b),
    .b     (rd_a),
    .done  (div_done),
    .res   (div_res)
  );

  // stack memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[AW-1:0]] <= digit_fx;
    end else if (cmd.write_res) begin
      mem[count_m2[AW-1:0]] <= res.value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_operands) begin
      rd_a <= mem[count_m1[AW-1:0]];
      rd_b <= mem[count_m2[AW-1:0]];
    end else if (cmd.rd_bottom) begin
      rd_a <= mem[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tok) begin
      kind  <= tok_kind;
      digit <= tok_digit;
      op    <= op_t'(tok_op);
      last  <= tok_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= ST_OK;
    end else begin
      if (cmd.emit) begin
        count <= '0;
      end else if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.write_res) begin
        count <= count_m1;
      end

      // a hard error sticks; saturation is only a flag
      if (cmd.emit) begin
        err <= ST_OK;
      end else if (cmd.set_err) begin
        err <= cmd.err_code;
      end else if (cmd.write_res && res.sat) begin
        err <= ST_SATURATED;
      end else if (cmd.close_check && !is_hard(err) && count != CW'(1)) begin
        err <= ST_MALFORMED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value  <= is_hard(err) ? '0 : rd_a;
      out_status <= err;
    end
  end

  assign stat.kind       = kind;
  assign stat.last       = last;
  assign stat.op         = op;
  assign stat.digit_bad  = digit > MAX_DIGIT;
  assign stat.full       = count >= CW'(STACK_DEPTH);
  assign stat.lt2        = count < CW'(2);
  assign stat.hard       = is_hard(err);
  assign stat.right_zero = rd_a == '0;
  assign stat.unit_done  = mul_done | div_done;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ rtl/rsc_ctrl.sv @@
`default_nettype none

module rsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_valid,
  output logic           tok_ready,
  input  rsc_pkg::stat_t stat,
  output rsc_pkg::cmd_t  cmd
);
  import rsc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    tok_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        tok_ready = 1'b1;
        if (tok_valid) begin
          cmd.load_tok = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_CLOSE;
        // after a hard error the token is dropped, but a last token still closes
        if (!stat.hard) begin
          if (stat.kind == KIND_DIGIT) begin
            if (stat.digit_bad) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_MALFORMED;
            end else if (stat.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (stat.lt2) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_MALFORMED;
          end else begin
            cmd.rd_operands = 1'b1;
            state_next      = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_next = S_CLOSE;
        if (stat.op inside {OP_ADD, OP_SUB}) begin
          cmd.write_res = 1'b1;
        end else if (stat.op == OP_MUL) begin
          cmd.start_mul = 1'b1;
          state_next    = S_ARITH;
        end else if (stat.right_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZERO;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_ARITH;
        end
      end
      S_ARITH: begin
        if (stat.unit_done) begin
          cmd.write_res = 1'b1;
          state_next    = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (stat.last) begin
          cmd.rd_bottom   = 1'b1;
          cmd.close_check = 1'b1;
          state_next      = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rpn_stack_calculator_unit.sv @@
`default_nettype none

// Channel   Dir  Word                                         Taken when
// token     in   kind, digit_value, op_code, last_token       valid & ready
// result    out  value (Q.FRACTION_BITS, 48b signed), status  valid & ready
//
// One token at a time. Digit: states IDLE, DECIDE, CLOSE. Add/subtract: IDLE, DECIDE, FETCH, CLOSE.
// Multiply: also waits in ARITH, set by the four 24x24 partial products of the multiplier.
// Divide: also waits in ARITH, set by the one-bit-per-cycle divider.
// A last token adds the EMIT state, plus any wait for the result register to empty.
// rst (synchronous) empties the stack and clears the error and the result valid flag.
// token.ready is low while a token is being worked; a stalled result does not block
// tokens other than the next last token.

module rpn_stack_calculator_unit #(
  parameter int STACK_DEPTH   = rsc_pkg::DEF_STACK_DEPTH,
  parameter int FRACTION_BITS = rsc_pkg::DEF_FRACTION_BITS
) (
  input logic       clk,
  input logic       rst,
  rsc_tok_if.sink   token,
  rsc_res_if.source result
);
  import rsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (token.valid),
    .tok_ready (token.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsc_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .tok_kind   (token.kind),
    .tok_digit  (token.digit_value),
    .tok_op     (token.op_code),
    .tok_last   (token.last_token),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .out_value  (result.value),
    .out_status (result.status)
  );

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.write_res, cmd.start_mul, cmd.start_div, cmd.emit}))
    else $error("conflicting stack actions in one cycle");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result written over an untaken word");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> stat.lt2 && !stat.hard)
    else $error("stack or error not cleared after result");

  a_pop_two: assert property (@(posedge clk) disable iff (rst)
    cmd.write_res |-> !stat.lt2)
    else $error("operator result written with fewer than two operands");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rsc_pkg::*;

  localparam int DEPTH        = DEF_STACK_DEPTH;
  localparam int FRAC         = DEF_FRACTION_BITS;
  localparam int TOTAL_TOKENS = 1250;
  localparam int CALM_AFTER   = 1000;
  localparam int DRAIN_CYCLES = 100;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t value;
    logic sat;
  } fx_t;

  typedef struct packed {
    val_t    value;
    status_t status;
  } answer_t;

  logic clk = 1'b0;
  logic rst;
  logic idle_en = 1'b1;
  logic rx_hold = 1'b0;
  logic rx_ready = 1'b0;
  int   rx_left = 0;
  int   tok_count = 0;
  int   err_cnt = 0;

  // Calculator state as seen by the testbench
  val_t    calc_stack [DEPTH];
  int      calc_depth = 0;
  status_t calc_err = ST_OK;
  answer_t rpn_answers [$];

  rsc_tok_if tok_if();
  rsc_res_if res_if();

  assign res_if.ready = rx_ready;

  rpn_stack_calculator_unit #(
    .STACK_DEPTH  (DEPTH),
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .token (tok_if),
    .result(res_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- arithmetic

  function automatic bit is_fatal(status_t s);
    return s == ST_MALFORMED || s == ST_OVERFLOW || s == ST_DIVZERO;
  endfunction

  function automatic logic [127:0] mag128(val_t v);
    logic [VAL_W-1:0] u;
    u = v[VAL_W-1] ? -v : v;
    return 128'(u);
  endfunction

  // Sign a magnitude and clamp it into the 48-bit range.
  function automatic fx_t fit(logic [127:0] m, logic neg);
    logic [127:0] cap;
    fx_t          r;
    cap   = 128'(VAL_MAX) + 128'(neg);
    r.sat = m > cap;
    if (r.sat) begin
      r.value = neg ? VAL_MIN : VAL_MAX;
    end else begin
      r.value = m[VAL_W-1:0];
      if (neg) r.value = -r.value;
    end
    return r;
  endfunction

  function automatic fx_t add_sat(val_t a, val_t b, logic minus);
    logic [VAL_W:0] s;
    fx_t            r;
    if (minus) s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    else       s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    r.sat = s[VAL_W] != s[VAL_W-1];
    if (r.sat) r.value = s[VAL_W] ? VAL_MIN : VAL_MAX;
    else       r.value = s[VAL_W-1:0];
    return r;
  endfunction

  function automatic fx_t mul_sat(val_t a, val_t b);
    return fit((mag128(a) * mag128(b)) >> FRAC, a[VAL_W-1] ^ b[VAL_W-1]);
  endfunction

  function automatic fx_t div_sat(val_t a, val_t b);
    return fit((mag128(a) << FRAC) / mag128(b), a[VAL_W-1] ^ b[VAL_W-1]);
  endfunction

  function automatic void apply_token(logic kind, logic [DIGIT_W-1:0] dig, op_t op);
    val_t lhs;
    val_t rhs;
    fx_t  r;
    if (kind == KIND_DIGIT) begin
      if (dig > MAX_DIGIT) begin
        calc_err = ST_MALFORMED;
      end else if (calc_depth >= DEPTH) begin
        calc_err = ST_OVERFLOW;
      end else begin
        calc_stack[calc_depth] = VAL_W'(dig) << FRAC;
        calc_depth++;
      end
    end else if (calc_depth < 2) begin
      calc_err = ST_MALFORMED;
    end else begin
      rhs = calc_stack[calc_depth-1];
      lhs = calc_stack[calc_depth-2];
      if (op == OP_DIV && rhs == 0) begin
        calc_err = ST_DIVZERO;
      end else begin
        case (op)
          OP_ADD:  r = add_sat(lhs, rhs, 1'b0);
          OP_SUB:  r = add_sat(lhs, rhs, 1'b1);
          OP_MUL:  r = mul_sat(lhs, rhs);
          default: r = div_sat(lhs, rhs);
        endcase
        calc_depth--;
        calc_stack[calc_depth-1] = r.value;
        if (r.sat) calc_err = ST_SATURATED;
      end
    end
  endfunction

  function automatic void rpn_eval(logic kind, logic [DIGIT_W-1:0] dig, op_t op, logic last);
    answer_t a;
    if (!is_fatal(calc_err)) apply_token(kind, dig, op);
    if (last) begin
      if (!is_fatal(calc_err) && calc_depth != 1) calc_err = ST_MALFORMED;
      a.status = calc_err;
      a.value  = is_fatal(calc_err) ? '0 : calc_stack[0];
      rpn_answers.push_back(a);
      calc_depth = 0;
      calc_err   = ST_OK;
    end
  endfunction

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    if (rst) begin
      rx_ready <= 1'b0;
      rx_left  <= 0;
    end else if (rx_hold) begin
      rx_ready <= 1'b0;
    end else if (!idle_en) begin
      rx_ready <= 1'b1;
    end else if (rx_left == 0) begin
      rx_ready <= 1'($urandom_range(1, 0));
      rx_left  <= $urandom_range(19, 1);
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (rpn_answers.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result word: value %0d status %0d",
                   res_if.value, res_if.status);
      end else begin
        want = rpn_answers.pop_front();
        if (res_if.value !== want.value || res_if.status !== want.status) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                     want.value, want.status, res_if.value, res_if.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- token side

  task automatic send_token(logic kind, logic [DIGIT_W-1:0] dig, logic [OP_W-1:0] op,
                            logic last);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(3, 0) == 0) gap = $urandom_range(19, 1);
    if (gap != 0) begin
      tok_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tok_if.valid       <= 1'b1;
    tok_if.kind        <= kind;
    tok_if.digit_value <= dig;
    tok_if.op_code     <= op;
    tok_if.last_token  <= last;
    @(posedge clk);
    while (!tok_if.ready) @(posedge clk);
    rpn_eval(kind, dig, op_t'(op), last);
    tok_count++;
  endtask

  task automatic send_digit(logic [DIGIT_W-1:0] dig, logic last);
    send_token(KIND_DIGIT, dig, OP_W'($urandom_range(3, 0)), last);
  endtask

  task automatic send_op(op_t op, logic last);
    send_token(KIND_OPER, DIGIT_W'($urandom_range(15, 0)), op, last);
  endtask

  // Send a postfix string; the final character carries last_token.
  task automatic send_expr(string s);
    int   i;
    logic l;
    for (i = 0; i < s.len(); i++) begin
      l = (i == s.len() - 1);
      case (s[i])
        "+":     send_op(OP_ADD, l);
        "-":     send_op(OP_SUB, l);
        "*":     send_op(OP_MUL, l);
        "/":     send_op(OP_DIV, l);
        default: send_digit(DIGIT_W'(s[i] - "0"), l);
      endcase
    end
  endtask

  // Well-formed expression with n_ops operators; chain mode favors multiply.
  task automatic send_formula(int n_ops, int max_d, int push_pct, bit chain);
    int   depth;
    int   pushes;
    int   ops;
    bit   can_push;
    bit   can_op;
    op_t  op;
    depth  = 0;
    pushes = n_ops + 1;
    ops    = n_ops;
    while (pushes + ops > 0) begin
      can_push = pushes > 0 && depth < max_d;
      can_op   = depth >= 2 && ops > 0;
      if (can_push && (!can_op || $urandom_range(99, 0) < push_pct)) begin
        pushes--;
        depth++;
        if (chain) send_digit(DIGIT_W'($urandom_range(9, 4)), pushes + ops == 0);
        else       send_digit(DIGIT_W'($urandom_range(9, 0)), pushes + ops == 0);
      end else begin
        ops--;
        depth--;
        op = op_t'($urandom_range(3, 0));
        if (chain && $urandom_range(3, 0) != 0) op = OP_MUL;
        send_op(op, pushes + ops == 0);
      end
    end
  endtask

  task automatic hold_results(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  task automatic wait_results_drained();
    tok_if.valid <= 1'b0;
    while (rpn_answers.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_basic_arith();
    send_expr("9");
    send_expr("0");
    send_expr("12+");
    send_expr("35-");
    send_expr("99*");
    send_expr("72/");
    send_expr("01-3/");
  endtask

  task automatic test_malformed();
    send_expr("+");
    send_expr("5*");
    send_expr("12");
    send_token(KIND_DIGIT, 4'd15, OP_W'(OP_ADD), 1'b1);
    // tokens after a bad digit are dropped
    send_digit(4'd3, 1'b0);
    send_token(KIND_DIGIT, 4'd10, OP_W'(OP_SUB), 1'b0);
    send_op(OP_ADD, 1'b1);
  endtask

  task automatic test_divide_by_zero();
    send_expr("40/");
    send_expr("40/5+");
  endtask

  task automatic test_saturation();
    send_expr("99*9*9*9*9*9*9*9*9*9*");
    send_expr("09-9*9*9*9*9*9*9*9*9*9*");
    send_expr("99*9*9*9*9*9*9*9*9*9*19//");
    send_expr("99*9*9*9*9*9*9*9*9*9*0/");
  endtask

  task automatic test_stack_overflow();
    int i;
    for (i = 0; i < DEPTH + 1; i++) send_digit(DIGIT_W'($urandom_range(9, 0)), i == DEPTH);
  endtask

  task automatic test_result_backpressure();
    // hold the result port so the second last token backs up the token port
    fork
      hold_results(300);
    join_none
    repeat (4) begin
      send_expr("12+");
      send_expr("7");
    end
    wait_results_drained();
  endtask

  task automatic test_random_expressions();
    int pick;
    int n;
    int i;
    while (tok_count < TOTAL_TOKENS) begin
      if (tok_count >= CALM_AFTER) idle_en <= 1'b0;
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        if ($urandom_range(5, 0) == 0) n = $urandom_range(20, 6);
        else                           n = $urandom_range(5, 0);
        send_formula(n, $urandom_range(6, 2), 50, 1'b0);
      end else if (pick < 75) begin
        send_formula($urandom_range(DEPTH - 1, 16), DEPTH, 100, 1'b0);
      end else if (pick < 85) begin
        send_formula($urandom_range(14, 8), 2, 50, 1'b1);
      end else if (pick < 88) begin
        n = $urandom_range(DEPTH + 3, DEPTH + 1);
        for (i = 0; i < n; i++) send_digit(DIGIT_W'($urandom_range(9, 0)), 1'b0);
        send_op(op_t'($urandom_range(3, 0)), 1'b1);
      end else begin
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++)
          send_token(1'($urandom_range(1, 0)), DIGIT_W'($urandom_range(15, 0)),
                     OP_W'($urandom_range(3, 0)), i == n - 1);
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                <= 1'b1;
    tok_if.valid       <= 1'b0;
    tok_if.kind        <= KIND_DIGIT;
    tok_if.digit_value <= '0;
    tok_if.op_code     <= OP_W'(OP_ADD);
    tok_if.last_token  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_basic_arith();
    test_malformed();
    test_divide_by_zero();
    test_saturation();
    test_stack_overflow();
    test_result_backpressure();
    test_random_expressions();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    // 10 ms
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ rpn_stack_calculator_unit.f @@
rtl/rsc_pkg.sv
rtl/rsc_if.sv
rtl/rsc_mul.sv
rtl/rsc_div.sv
rtl/rsc_dp.sv
rtl/rsc_ctrl.sv
rtl/rpn_stack_calculator_unit.sv
dv/tb_top.sv
